### rtl/spl_pkg.sv
package spl_pkg;

    // Default field widths.
    localparam int IN_WIDTH_DEF       = 24;
    localparam int OUT_WIDTH_DEF      = 16;
    localparam int GAIN_FRAC_BITS_DEF = 24;

    // Configuration registers.
    localparam int VOL_W       = 17;
    localparam int THR_W       = 17;
    localparam int COEFF_W     = 25;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 2;
    localparam int VOL_FRAC    = 16;
    localparam int COEFF_FRAC  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_VOLUME   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEFF   = 2'd2;

    localparam logic [VOL_W-1:0]   UNIT16      = 17'd65536;
    localparam logic [COEFF_W-1:0] COEFF_ONE   = 25'd16777216;
    localparam logic [VOL_W-1:0]   VOL_RESET   = 17'd65536;
    localparam logic [THR_W-1:0]   THR_RESET   = 17'd58982;
    localparam logic [COEFF_W-1:0] COEFF_RESET = 25'd1748;

    // Operations of the shared serial unit.
    typedef enum logic [1:0] {
        OP_VOL   = 2'd0,
        OP_GAIN  = 2'd1,
        OP_COEFF = 2'd2,
        OP_DIV   = 2'd3
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Width of the scaled threshold, which is also the quotient width.
    function automatic int num_width(input int in_w, input int g);
        return in_w - 5 + g + 1;
    endfunction

    // Width of the multiplier / divisor operand register.
    function automatic int b_width(input int in_w, input int g);
        return max2(max2(g + 1, COEFF_W), max2(in_w, VOL_W));
    endfunction

    // Accumulator width: covers every product and the saturating release product.
    function automatic int acc_width(input int in_w, input int g);
        return max2(max2(in_w + g + 1, g + 26), max2(num_width(in_w, g), in_w + VOL_W));
    endfunction

    function automatic int step_width(input int in_w, input int g);
        return $clog2(max2(num_width(in_w, g), b_width(in_w, g)) + 1);
    endfunction

endpackage

### rtl/stereo_peak_limiter.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  tdata: left_in, right_in; tlast: block_end
// m_        out        m_tvalid / m_tready  tdata: left_out, right_out, gain_now;
//                                           tlast: block_end_out
// cfg_      in         cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
// Each frame scales both inputs by the volume, checks the peak and scales both outputs;
// the divide is added when limiting is needed, and the release step unless a new gain
// is taken at once. Every multiply and the divide run one bit per cycle through the
// single shared serial unit; the divide, at IN_WIDTH+GAIN_FRAC_BITS-4 steps, is the
// longest operation.
// Reset is synchronous and active low; it restores the register defaults and a gain of 1.0.
// A finished result waits in the output register, and the next frame can be accepted
// meanwhile; the block only holds in its final state if that register is still full.
module stereo_peak_limiter #(
    parameter int IN_WIDTH       = spl_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH      = spl_pkg::OUT_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = spl_pkg::GAIN_FRAC_BITS_DEF,
    localparam int S_DATA_W = ((2 * IN_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * OUT_WIDTH + GAIN_FRAC_BITS + 1 + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_DATA_W-1:0]              s_tdata,   // left_in, right_in
    input  logic                             s_tlast,   // block_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_DATA_W-1:0]              m_tdata,   // left_out, right_out, gain_now
    output logic                             m_tlast,   // block_end_out
    input  logic                             cfg_wr_en,
    input  logic [spl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IN_FRAC = IN_WIDTH - 5;
    localparam int GW      = GAIN_FRAC_BITS + 1;
    localparam int NUM_W   = spl_pkg::num_width(IN_WIDTH, GAIN_FRAC_BITS);
    localparam int ACC_W   = spl_pkg::acc_width(IN_WIDTH, GAIN_FRAC_BITS);
    localparam int B_W     = spl_pkg::b_width(IN_WIDTH, GAIN_FRAC_BITS);
    localparam int THR_SH  = IN_FRAC + GAIN_FRAC_BITS - spl_pkg::VOL_FRAC;
    localparam int OUT_SH  = IN_FRAC + GAIN_FRAC_BITS - (OUT_WIDTH - 1);

    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;
    localparam longint unsigned FLOOR_RAW = ((64'd1 << IN_FRAC) + 64'd5000) / 64'd10000;
    localparam logic [IN_WIDTH-1:0] PEAK_FLOOR =
        (FLOOR_RAW == 64'd0) ? IN_WIDTH'(1) : IN_WIDTH'(FLOOR_RAW);
    localparam logic [ACC_W-1:0] OUT_MAX = (ACC_W'(1) << (OUT_WIDTH - 1)) - ACC_W'(1);
    localparam logic [ACC_W:0] RND_ADD = (ACC_W + 1)'(spl_pkg::COEFF_ONE - 1'b1);

    // Sequencer: each unit operation has a start state and a wait state.
    typedef enum logic [15:0] {
        ST_IDLE       = 16'b0000_0000_0000_0001,
        ST_VOL_L      = 16'b0000_0000_0000_0010,
        ST_VOL_L_WAIT = 16'b0000_0000_0000_0100,
        ST_VOL_R      = 16'b0000_0000_0000_1000,
        ST_VOL_R_WAIT = 16'b0000_0000_0001_0000,
        ST_PEAK       = 16'b0000_0000_0010_0000,
        ST_PEAK_WAIT  = 16'b0000_0000_0100_0000,
        ST_DIV        = 16'b0000_0000_1000_0000,
        ST_DIV_WAIT   = 16'b0000_0001_0000_0000,
        ST_REL        = 16'b0000_0010_0000_0000,
        ST_REL_WAIT   = 16'b0000_0100_0000_0000,
        ST_OUT_L      = 16'b0000_1000_0000_0000,
        ST_OUT_L_WAIT = 16'b0001_0000_0000_0000,
        ST_OUT_R      = 16'b0010_0000_0000_0000,
        ST_OUT_R_WAIT = 16'b0100_0000_0000_0000,
        ST_DONE       = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [spl_pkg::VOL_W-1:0]   vol_reg;
    logic [spl_pkg::THR_W-1:0]   thr_reg;
    logic [spl_pkg::COEFF_W-1:0] coeff_reg;

    // Held limiter gain, the only state that carries from frame to frame.
    logic [GW-1:0] gain_reg;

    // Per-frame working registers.
    logic [IN_WIDTH-1:0]  mag_l_reg, mag_r_reg, peak_reg;
    logic                 neg_l_reg, neg_r_reg, last_reg;
    logic [NUM_W-1:0]     target_reg;
    logic [OUT_WIDTH-1:0] y_l_reg, y_r_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [OUT_WIDTH-1:0] out_l_reg, out_r_reg;
    logic [GW-1:0]        out_gain_reg;
    logic                 out_last_reg;

    spl_pkg::unit_ctrl_t unit_ctrl;
    spl_pkg::unit_stat_t unit_stat;
    logic [ACC_W-1:0]    unit_a;
    logic [B_W-1:0]      unit_b;
    logic [ACC_W-1:0]    unit_acc;

    spl_serial_unit #(
        .IN_WIDTH       (IN_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (unit_ctrl),
        .a_in    (unit_a),
        .b_in    (unit_b),
        .stat    (unit_stat),
        .acc     (unit_acc)
    );

    // Input decode: sign and magnitude; the most negative value keeps its full magnitude.
    logic [IN_WIDTH-1:0] in_l, in_r, in_mag_l, in_mag_r;
    assign in_l     = s_tdata[IN_WIDTH-1:0];
    assign in_r     = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
    assign in_mag_l = in_l[IN_WIDTH-1] ? (~in_l + IN_WIDTH'(1)) : in_l;
    assign in_mag_r = in_r[IN_WIDTH-1] ? (~in_r + IN_WIDTH'(1)) : in_r;

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Derived values used by the sequencer.
    logic [NUM_W-1:0]    thr_scaled;
    logic [IN_WIDTH-1:0] vol_result, peak_now, divisor;
    logic                over_limit, attack;
    logic [NUM_W-1:0]    rel_diff;
    logic [ACC_W:0]      rel_rounded, rel_step, rel_sum;
    logic [GW-1:0]       rel_gain;
    logic [ACC_W-1:0]    out_scaled;
    logic [OUT_WIDTH-1:0] out_mag;

    assign thr_scaled = NUM_W'(thr_reg) << THR_SH;
    assign vol_result = IN_WIDTH'(unit_acc >> spl_pkg::VOL_FRAC);
    assign peak_now   = (mag_l_reg > mag_r_reg) ? mag_l_reg : mag_r_reg;
    assign divisor    = (peak_reg > PEAK_FLOOR) ? peak_reg : PEAK_FLOOR;
    assign over_limit = unit_acc > ACC_W'(thr_scaled);
    assign attack     = target_reg < NUM_W'(gain_reg);
    assign rel_diff   = target_reg - NUM_W'(gain_reg);

    // Release step is rounded up, so a nonzero coefficient always reaches the target.
    assign rel_rounded = {1'b0, unit_acc} + RND_ADD;
    assign rel_step    = rel_rounded >> spl_pkg::COEFF_FRAC;
    assign rel_sum     = rel_step + (ACC_W + 1)'(gain_reg);
    assign rel_gain    = (rel_sum > (ACC_W + 1)'(GAIN_ONE)) ? GAIN_ONE : rel_sum[GW-1:0];

    // Output scaling: truncate the product, then clip to the largest positive code.
    assign out_scaled = unit_acc >> OUT_SH;
    assign out_mag    = (out_scaled > OUT_MAX) ? OUT_MAX[OUT_WIDTH-1:0]
                                               : out_scaled[OUT_WIDTH-1:0];

    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Operand selection for the shared unit.
    always_comb begin
        unit_ctrl.start = 1'b0;
        unit_ctrl.op    = spl_pkg::OP_VOL;
        unit_a          = ACC_W'(mag_l_reg);
        unit_b          = B_W'(vol_reg);
        case (state_reg)
            ST_VOL_L: begin
                unit_ctrl.start = !unit_stat.busy;
            end
            ST_VOL_R: begin
                unit_ctrl.start = !unit_stat.busy;
                unit_a          = ACC_W'(mag_r_reg);
            end
            ST_PEAK: begin
                unit_ctrl.start = !unit_stat.busy;
                unit_ctrl.op    = spl_pkg::OP_GAIN;
                unit_a          = ACC_W'(peak_now);
                unit_b          = B_W'(gain_reg);
            end
            ST_DIV: begin
                unit_ctrl.start = !unit_stat.busy;
                unit_ctrl.op    = spl_pkg::OP_DIV;
                unit_a          = ACC_W'(thr_scaled);
                unit_b          = B_W'(divisor);
            end
            ST_REL: begin
                unit_ctrl.start = !attack && !unit_stat.busy;
                unit_ctrl.op    = spl_pkg::OP_COEFF;
                unit_a          = ACC_W'(rel_diff);
                unit_b          = B_W'(coeff_reg);
            end
            ST_OUT_L: begin
                unit_ctrl.start = !unit_stat.busy;
                unit_ctrl.op    = spl_pkg::OP_GAIN;
                unit_b          = B_W'(gain_reg);
            end
            ST_OUT_R: begin
                unit_ctrl.start = !unit_stat.busy;
                unit_ctrl.op    = spl_pkg::OP_GAIN;
                unit_a          = ACC_W'(mag_r_reg);
                unit_b          = B_W'(gain_reg);
            end
            default: begin
                unit_ctrl.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_fire) state_next = ST_VOL_L;
            ST_VOL_L:      state_next = ST_VOL_L_WAIT;
            ST_VOL_L_WAIT: if (unit_stat.done) state_next = ST_VOL_R;
            ST_VOL_R:      state_next = ST_VOL_R_WAIT;
            ST_VOL_R_WAIT: if (unit_stat.done) state_next = ST_PEAK;
            ST_PEAK:       state_next = ST_PEAK_WAIT;
            ST_PEAK_WAIT: begin
                if (unit_stat.done) begin
                    state_next = over_limit ? ST_DIV : ST_REL;
                end
            end
            ST_DIV:        state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:   if (unit_stat.done) state_next = ST_REL;
            ST_REL:        state_next = attack ? ST_OUT_L : ST_REL_WAIT;
            ST_REL_WAIT:   if (unit_stat.done) state_next = ST_OUT_L;
            ST_OUT_L:      state_next = ST_OUT_L_WAIT;
            ST_OUT_L_WAIT: if (unit_stat.done) state_next = ST_OUT_R;
            ST_OUT_R:      state_next = ST_OUT_R_WAIT;
            ST_OUT_R_WAIT: if (unit_stat.done) state_next = ST_DONE;
            ST_DONE:       if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and held gain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            gain_reg    <= GAIN_ONE;
            vol_reg     <= spl_pkg::VOL_RESET;
            thr_reg     <= spl_pkg::THR_RESET;
            coeff_reg   <= spl_pkg::COEFF_RESET;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == ST_REL && attack) begin
                gain_reg <= target_reg[GW-1:0];
            end else if (state_reg == ST_REL_WAIT && unit_stat.done) begin
                gain_reg <= rel_gain;
            end

            // Fields saturate at 1.0; extra data bits and unknown indexes are dropped.
            if (cfg_wr_en) begin
                case (cfg_index)
                    spl_pkg::REG_MASTER_VOLUME: begin
                        vol_reg <= (cfg_wdata[spl_pkg::VOL_W-1:0] > spl_pkg::UNIT16)
                                   ? spl_pkg::UNIT16 : cfg_wdata[spl_pkg::VOL_W-1:0];
                    end
                    spl_pkg::REG_LIMIT_THRESHOLD: begin
                        thr_reg <= (cfg_wdata[spl_pkg::THR_W-1:0] > spl_pkg::UNIT16)
                                   ? spl_pkg::UNIT16 : cfg_wdata[spl_pkg::THR_W-1:0];
                    end
                    spl_pkg::REG_RELEASE_COEFF: begin
                        coeff_reg <= (cfg_wdata[spl_pkg::COEFF_W-1:0] > spl_pkg::COEFF_ONE)
                                     ? spl_pkg::COEFF_ONE : cfg_wdata[spl_pkg::COEFF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers; the magnitudes are overwritten with their scaled values.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mag_l_reg <= in_mag_l;
            mag_r_reg <= in_mag_r;
            neg_l_reg <= in_l[IN_WIDTH-1];
            neg_r_reg <= in_r[IN_WIDTH-1];
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_VOL_L_WAIT && unit_stat.done) begin
            mag_l_reg <= vol_result;
        end
        if (state_reg == ST_VOL_R_WAIT && unit_stat.done) begin
            mag_r_reg <= vol_result;
        end
        if (state_reg == ST_PEAK) begin
            peak_reg <= peak_now;
        end
        if (state_reg == ST_PEAK_WAIT && unit_stat.done && !over_limit) begin
            target_reg <= NUM_W'(GAIN_ONE);
        end
        if (state_reg == ST_DIV_WAIT && unit_stat.done) begin
            target_reg <= unit_acc[NUM_W-1:0];
        end
        if (state_reg == ST_OUT_L_WAIT && unit_stat.done) begin
            y_l_reg <= neg_l_reg ? (~out_mag + OUT_WIDTH'(1)) : out_mag;
        end
        if (state_reg == ST_OUT_R_WAIT && unit_stat.done) begin
            y_r_reg <= neg_r_reg ? (~out_mag + OUT_WIDTH'(1)) : out_mag;
        end
        if (out_load) begin
            out_l_reg    <= y_l_reg;
            out_r_reg    <= y_r_reg;
            out_gain_reg <= gain_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({out_gain_reg, out_r_reg, out_l_reg});
    assign m_tlast  = out_last_reg;

endmodule

### rtl/spl_serial_unit.sv
// One bit per cycle: MSB-first shift-add multiply (saturating) or restoring divide.
module spl_serial_unit #(
    parameter int IN_WIDTH       = spl_pkg::IN_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = spl_pkg::GAIN_FRAC_BITS_DEF,
    localparam int ACC_W = spl_pkg::acc_width(IN_WIDTH, GAIN_FRAC_BITS),
    localparam int B_W   = spl_pkg::b_width(IN_WIDTH, GAIN_FRAC_BITS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  spl_pkg::unit_ctrl_t ctrl,
    input  logic [ACC_W-1:0]    a_in,
    input  logic [B_W-1:0]      b_in,
    output spl_pkg::unit_stat_t stat,
    output logic [ACC_W-1:0]    acc
);

    localparam int NUM_W  = spl_pkg::num_width(IN_WIDTH, GAIN_FRAC_BITS);
    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int STEP_W = spl_pkg::step_width(IN_WIDTH, GAIN_FRAC_BITS);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  a_reg;
    logic [B_W-1:0]    b_reg, b_next;
    logic [IN_WIDTH-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] cnt_reg;
    spl_pkg::unit_op_t op_reg;
    logic              busy_reg, done_reg;

    logic [ACC_W-1:0]  mul_add;
    logic [ACC_W+1:0]  mul_sum;
    logic [IN_WIDTH:0] rem_sh, rem_diff;
    logic              div_ge;
    logic [STEP_W-1:0] load_steps;
    logic [B_W-1:0]    load_b;

    // Operand alignment so that the multiplier's top bit sits at the MSB.
    always_comb begin
        case (ctrl.op)
            spl_pkg::OP_VOL: begin
                load_steps = STEP_W'(spl_pkg::VOL_W);
                load_b     = b_in << (B_W - spl_pkg::VOL_W);
            end
            spl_pkg::OP_GAIN: begin
                load_steps = STEP_W'(GAIN_W);
                load_b     = b_in << (B_W - GAIN_W);
            end
            spl_pkg::OP_COEFF: begin
                load_steps = STEP_W'(spl_pkg::COEFF_W);
                load_b     = b_in << (B_W - spl_pkg::COEFF_W);
            end
            default: begin
                load_steps = STEP_W'(NUM_W);
                load_b     = b_in;
            end
        endcase
    end

    always_comb begin
        mul_add  = b_reg[B_W-1] ? a_reg : '0;
        mul_sum  = {1'b0, acc_reg, 1'b0} + {2'b00, mul_add};
        rem_sh   = {rem_reg, acc_reg[NUM_W-1]};
        div_ge   = rem_sh >= {1'b0, b_reg[IN_WIDTH-1:0]};
        rem_diff = rem_sh - {1'b0, b_reg[IN_WIDTH-1:0]};
        if (op_reg == spl_pkg::OP_DIV) begin
            acc_next = {acc_reg[ACC_W-2:0], div_ge};
            rem_next = div_ge ? rem_diff[IN_WIDTH-1:0] : rem_sh[IN_WIDTH-1:0];
            b_next   = b_reg;
        end else begin
            // Saturation is monotone, so a clipped product still compares correctly.
            acc_next = (mul_sum[ACC_W+1:ACC_W] != 2'b00) ? '1 : mul_sum[ACC_W-1:0];
            rem_next = rem_reg;
            b_next   = {b_reg[B_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= load_steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start && !busy_reg) begin
            op_reg  <= ctrl.op;
            a_reg   <= a_in;
            b_reg   <= load_b;
            rem_reg <= '0;
            acc_reg <= (ctrl.op == spl_pkg::OP_DIV) ? a_in : '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= b_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;

endmodule

### rtl/spl_checker.sv
// Port-level checks for the limiter.
module spl_checker #(
    parameter int IN_WIDTH       = spl_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH      = spl_pkg::OUT_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = spl_pkg::GAIN_FRAC_BITS_DEF,
    localparam int S_DATA_W = ((2 * IN_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * OUT_WIDTH + GAIN_FRAC_BITS + 1 + 7) / 8) * 8
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [S_DATA_W-1:0]             s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [M_DATA_W-1:0]             m_tdata,
    input logic                            m_tlast,
    input logic                            cfg_wr_en,
    input logic [spl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [spl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;
    localparam logic [OUT_WIDTH-1:0] OUT_MOST_NEG = OUT_WIDTH'(1) << (OUT_WIDTH - 1);

    logic [GW-1:0]        gain_field;
    logic [OUT_WIDTH-1:0] left_field, right_field;
    assign left_field  = m_tdata[OUT_WIDTH-1:0];
    assign right_field = m_tdata[2*OUT_WIDTH-1:OUT_WIDTH];
    assign gain_field  = m_tdata[2*OUT_WIDTH+GW-1:2*OUT_WIDTH];

    // A frame holds the sequencer busy once accepted, so input closes right after a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready right after a transaction");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed or dropped");

    a_gain_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> gain_field <= GAIN_ONE)
        else $error("reported gain above unity");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (left_field != OUT_MOST_NEG) && (right_field != OUT_MOST_NEG))
        else $error("output sample outside the clipping range");

endmodule

bind stereo_peak_limiter spl_checker #(
    .IN_WIDTH       (IN_WIDTH),
    .OUT_WIDTH      (OUT_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
) u_spl_checker (.*);
